/* design/slt_pkg.sv */
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int VAL_W    = 32;

  localparam logic [CNT_W-1:0] NIL = '1;

  typedef enum logic [1:0] {
    CMD_INS = 2'd0,
    CMD_DEL = 2'd1,
    CMD_RD  = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

endpackage

/* design/sorted_linked_list_table.sv */
// Read and clear go straight to the finish state; insert walks the list, one link step a cycle;
// delete adds a search and compaction of one slot a cycle, then re-inserts every kept value.
// Throughput: one command at a time, set by the single compare and link-walk unit.
// A finished result may wait in the output register while the next command is taken.
// Reset: synchronous, active high; table empty (head -1, count 0), no result pending.
module sorted_linked_list_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  slt_pkg::cmd_t                       cmd,
  input  logic signed [slt_pkg::VAL_W-1:0]    value,
  input  logic        [slt_pkg::SLOT_W-1:0]   index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output slt_pkg::status_t                    status,
  output logic signed [slt_pkg::CNT_W-1:0]    link,
  output logic signed [slt_pkg::CNT_W-1:0]    head,
  output logic        [slt_pkg::CNT_W-1:0]    count
);
  import slt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  logic signed [VAL_W-1:0] values [CAPACITY];
  logic [CNT_W-1:0]        links  [CAPACITY];

  state_t                  state, state_next;
  cmd_t                    op, op_next;
  status_t                 res, res_next;
  logic signed [VAL_W-1:0] arg, arg_next;
  logic [SLOT_W-1:0]       sel, sel_next;
  logic [CNT_W-1:0]        cur, cur_next;
  logic [CNT_W-1:0]        prev, prev_next;
  logic [CNT_W-1:0]        ptr, ptr_next;
  logic [CNT_W-1:0]        total, total_next;
  logic [CNT_W-1:0]        head_slot, head_slot_next;
  logic [CNT_W-1:0]        fill, fill_next;

  logic [SLOT_W-1:0]       rd_addr;
  logic signed [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0]        rd_lnk;
  logic                    val_we, lnk_we, ld_out;
  logic [SLOT_W-1:0]       val_wa, lnk_wa;
  logic signed [VAL_W-1:0] val_wd;
  logic [CNT_W-1:0]        lnk_wd;
  logic [CNT_W-1:0]        fill_inc;
  logic                    more;

  always_comb begin
    unique case (state)
      S_WALK:   rd_addr = cur[SLOT_W-1:0];
      S_SEARCH: rd_addr = ptr[SLOT_W-1:0];
      S_SHIFT:  rd_addr = ptr[SLOT_W-1:0] + SLOT_W'(1);
      S_LOAD:   rd_addr = fill[SLOT_W-1:0];
      default:  rd_addr = sel;
    endcase
  end

  assign rd_val   = values[rd_addr];
  assign rd_lnk   = links[rd_addr];
  assign fill_inc = fill + CNT_W'(1);
  assign more     = (op == CMD_DEL) && (fill_inc < total);

  always_comb begin
    state_next     = state;
    op_next        = op;
    res_next       = res;
    arg_next       = arg;
    sel_next       = sel;
    cur_next       = cur;
    prev_next      = prev;
    ptr_next       = ptr;
    total_next     = total;
    head_slot_next = head_slot;
    fill_next      = fill;
    val_we         = 1'b0;
    val_wa         = fill[SLOT_W-1:0];
    val_wd         = arg;
    lnk_we         = 1'b0;
    lnk_wa         = fill[SLOT_W-1:0];
    lnk_wd         = cur;
    ld_out         = 1'b0;
    in_stall       = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next  = cmd;
          sel_next = index;
          arg_next = value;
          res_next = ST_OK;
          ptr_next = '0;
          unique case (cmd)
            CMD_INS: begin
              if (fill == CNT_W'(CAPACITY)) begin
                res_next   = ST_FULL;
                state_next = S_FINISH;
              end else begin
                cur_next   = head_slot;
                prev_next  = NIL;
                state_next = S_WALK;
              end
            end
            CMD_DEL: begin
              if (fill == '0) begin
                res_next   = ST_NOTFOUND;
                state_next = S_FINISH;
              end else begin
                state_next = S_SEARCH;
              end
            end
            CMD_RD: state_next = S_FINISH;
            CMD_CLR: begin
              head_slot_next = NIL;
              fill_next      = '0;
              state_next     = S_FINISH;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rd_val == arg) begin
          total_next = fill - CNT_W'(1);
          state_next = S_SHIFT;
        end else begin
          ptr_next = ptr + CNT_W'(1);
          if (ptr + CNT_W'(1) == fill) begin
            res_next   = ST_NOTFOUND;
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        if (ptr == total) begin
          head_slot_next = NIL;
          fill_next      = '0;
          state_next     = (total == '0) ? S_FINISH : S_LOAD;
        end else begin
          val_we   = 1'b1;
          val_wa   = ptr[SLOT_W-1:0];
          val_wd   = rd_val;
          ptr_next = ptr + CNT_W'(1);
        end
      end
      S_LOAD: begin
        arg_next   = rd_val;
        cur_next   = head_slot;
        prev_next  = NIL;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (cur[CNT_W-1] || (arg < rd_val)) begin
          val_we = 1'b1;
          lnk_we = 1'b1;
          if (prev[CNT_W-1]) begin
            head_slot_next = {1'b0, fill[SLOT_W-1:0]};
            fill_next      = fill_inc;
            state_next     = more ? S_LOAD : S_FINISH;
          end else begin
            state_next = S_FIX;
          end
        end else begin
          prev_next = cur;
          cur_next  = rd_lnk;
        end
      end
      S_FIX: begin
        lnk_we     = 1'b1;
        lnk_wa     = prev[SLOT_W-1:0];
        lnk_wd     = {1'b0, fill[SLOT_W-1:0]};
        fill_next  = fill_inc;
        state_next = more ? S_LOAD : S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          ld_out     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= NIL;
      fill      <= '0;
    end else begin
      state     <= state_next;
      head_slot <= head_slot_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    res   <= res_next;
    arg   <= arg_next;
    sel   <= sel_next;
    cur   <= cur_next;
    prev  <= prev_next;
    ptr   <= ptr_next;
    total <= total_next;
    if (val_we) begin
      values[val_wa] <= val_wd;
    end
    if (lnk_we) begin
      links[lnk_wa] <= lnk_wd;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      count <= fill;
      head  <= head_slot;
      if ({1'b0, sel} < fill) begin
        link   <= rd_lnk;
        status <= res;
      end else begin
        link   <= NIL;
        status <= (op == CMD_RD) ? ST_RANGE : res;
      end
    end
  end

endmodule

/* sim/slt_checker.sv */
`timescale 1ns / 1ps
module slt_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  slt_pkg::cmd_t                       cmd,
  input  logic signed [slt_pkg::VAL_W-1:0]    value,
  input  logic        [slt_pkg::SLOT_W-1:0]   index,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  slt_pkg::status_t                    status,
  input  logic signed [slt_pkg::CNT_W-1:0]    link,
  input  logic signed [slt_pkg::CNT_W-1:0]    head,
  input  logic        [slt_pkg::CNT_W-1:0]    count,
  output int                                  words_in,
  output int                                  words_out,
  output int                                  pending,
  output int                                  failures
);

  import slt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [CNT_W-1:0]   link;
    logic [CNT_W-1:0]   head;
    logic [CNT_W-1:0]   count;
  } table_reply_t;

  logic signed [VAL_W-1:0] slot_val  [CAPACITY];
  logic signed [CNT_W-1:0] slot_next [CAPACITY];
  logic signed [CNT_W-1:0] first_slot = NIL;
  int                      held = 0;
  table_reply_t            replies [$];

  function automatic void chain_value(input logic signed [VAL_W-1:0] v);
    int n;
    int prev;
    int cur;
    int steps;
    n     = held;
    prev  = -1;
    steps = 0;
    if (n >= CAPACITY) return;
    slot_val[n] = v;
    if (first_slot < 0) begin
      first_slot   = CNT_W'(n);
      slot_next[n] = NIL;
    end else if (v < slot_val[first_slot]) begin
      slot_next[n] = first_slot;
      first_slot   = CNT_W'(n);
    end else begin
      cur = int'(first_slot);
      while (cur >= 0 && steps < CAPACITY && !(v < slot_val[cur])) begin
        prev = cur;
        cur  = int'(slot_next[cur]);
        steps++;
      end
      if (prev >= 0) slot_next[prev] = CNT_W'(n);
      slot_next[n] = CNT_W'(cur);
    end
    held = n + 1;
  endfunction

  function automatic table_reply_t run_command(input cmd_t c,
                                               input logic signed [VAL_W-1:0] v,
                                               input logic [SLOT_W-1:0] idx);
    table_reply_t            r;
    logic signed [VAL_W-1:0] kept [$];
    int                      hit;
    r.status = ST_OK;
    r.link   = NIL;
    case (c)
      CMD_INS: begin
        if (held >= CAPACITY) r.status = ST_FULL;
        else chain_value(v);
      end
      CMD_DEL: begin
        hit = -1;
        for (int i = 0; i < held; i++)
          if (hit < 0 && slot_val[i] == v) hit = i;
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = 0; i < held; i++)
            if (i != hit) kept.push_back(slot_val[i]);
          first_slot = NIL;
          held       = 0;
          foreach (kept[k]) chain_value(kept[k]);
        end
      end
      CMD_CLR: begin
        first_slot = NIL;
        held       = 0;
      end
      default: ;
    endcase
    if (int'(idx) < held) r.link = slot_next[idx];
    else if (c == CMD_RD) r.status = ST_RANGE;
    r.head  = first_slot;
    r.count = CNT_W'(held);
    return r;
  endfunction

  function automatic void flag(input string field, input int want_v, input int got_v);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    failures++;
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t want;
    if (rst) begin
      first_slot = NIL;
      held       = 0;
      replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (replies.size() == 0) begin
          $display("%0t ns: unexpected word, status %0d link %0d head %0d count %0d",
                   $time, status, $signed(link), $signed(head), count);
          failures++;
        end else begin
          want = replies.pop_front();
          if (status !== want.status) flag("status", want.status, status);
          if (link !== want.link)
            flag("link", int'($signed(want.link)), int'($signed(link)));
          if (head !== want.head)
            flag("head", int'($signed(want.head)), int'($signed(head)));
          if (count !== want.count) flag("count", want.count, count);
        end
      end
      if (in_valid && !in_stall) begin
        words_in++;
        replies.push_back(run_command(cmd, value, index));
      end
    end
    pending = replies.size();
  end

endmodule

/* sim/tb_sorted_linked_list_table.sv */
`timescale 1ns / 1ps
module tb_sorted_linked_list_table;

  import slt_pkg::*;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    out_stall = 1'b0;
  cmd_t                    cmd       = CMD_RD;
  logic signed [VAL_W-1:0] value     = '0;
  logic [SLOT_W-1:0]       index     = '0;
  logic                    in_stall;
  logic                    out_valid;
  status_t                 status;
  logic signed [CNT_W-1:0] link;
  logic signed [CNT_W-1:0] head;
  logic [CNT_W-1:0]        count;

  int                      words_in;
  int                      words_out;
  int                      pending;
  int                      failures;
  int                      kinds [4];
  int                      cyc = 0;
  logic signed [VAL_W-1:0] pool  [8];

  always #5 clk = ~clk;

  sorted_linked_list_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .link      (link),
    .head      (head),
    .count     (count)
  );

  slt_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .link      (link),
    .head      (head),
    .count     (count),
    .words_in  (words_in),
    .words_out (words_out),
    .pending   (pending),
    .failures  (failures)
  );

  // free, jittery and heavy stall in turn
  always @(negedge clk) begin
    cyc++;
    case ((cyc / 200) % 3)
      0:       out_stall = 1'b0;
      1:       out_stall = 1'($urandom_range(0, 1));
      default: out_stall = (cyc % 5) != 0;
    endcase
  end

  task automatic send_word(input cmd_t c, input logic signed [VAL_W-1:0] v,
                           input logic [SLOT_W-1:0] idx);
    int taken;
    taken    = words_in;
    cmd      = c;
    value    = v;
    index    = idx;
    in_valid = 1'b1;
    kinds[int'(c)]++;
    do @(negedge clk); while (words_in == taken);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return pool[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin
    int   n_sent;
    int   burst;
    int   gap;
    int   roll;
    int   ins_w;
    cmd_t c;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(CMD_RD, 0, 0);
    send_word(CMD_DEL, 5, 3);
    send_word(CMD_INS, 32'sh7FFF_FFFF, 0);
    send_word(CMD_INS, 32'sh8000_0000, 1);
    send_word(CMD_INS, 0, 0);
    send_word(CMD_INS, -1, 2);
    send_word(CMD_INS, 0, 2);
    send_word(CMD_RD, 0, 1);
    send_word(CMD_RD, 0, 15);
    send_word(CMD_DEL, 0, 2);
    send_word(CMD_DEL, 12345, 0);
    for (int i = 0; i < 12; i++)
      send_word(CMD_INS, (i % 2) ? -i * 1000 : $urandom, SLOT_W'($urandom_range(0, 15)));
    send_word(CMD_INS, 77, 15);
    send_word(CMD_RD, 0, 15);
    send_word(CMD_CLR, 0, 0);
    in_valid = 1'b0;

    n_sent = 0;
    while (n_sent < 600) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        if (n_sent % 150 == 0)
          foreach (pool[p])
            pool[p] = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 8)) - 4;
        roll  = $urandom_range(0, 99);
        ins_w = ((n_sent / 100) % 2) ? 25 : 55;
        if (roll < ins_w) c = CMD_INS;
        else if (roll < 80) c = CMD_DEL;
        else if (roll < 96) c = CMD_RD;
        else c = CMD_CLR;
        send_word(c, (c == CMD_RD || c == CMD_CLR) ? $urandom : pick_value(),
                  SLOT_W'($urandom_range(0, 15)));
        n_sent++;
      end
      in_valid = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      repeat (gap) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Sent %0d commands: %0d insert, %0d delete, %0d read, %0d clear.",
             words_in, kinds[0], kinds[1], kinds[2], kinds[3]);
    $display("Checked %0d results, %0d field mismatches.", words_out, failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
